[sv/sts_pkg.sv]
// ============================================================================
// Script token splitter package
// Shared types and character codes for the tokenizer datapath.
// ============================================================================
package sts_pkg;

    // Default width of the line counter.
    localparam int LINE_BITS_DEF = 16;

    // Width of the line number carried on the result item.
    localparam int LINE_OUT_W = 16;

    // Character codes that steer the tokenizer.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Scanner mode held between bytes.
    typedef enum logic [1:0] {
        MODE_SKIP    = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_QUOTED  = 2'd2,
        MODE_PLAIN   = 2'd3
    } t_mode;

    // One result item as produced by the step logic.
    typedef struct packed {
        logic [7:0]            char_out;
        logic                  char_valid;
        logic                  token_start;
        logic                  token_end;
        logic                  is_quoted;
        logic                  spans_lines;
        logic [LINE_OUT_W-1:0] line_now;
    } t_result;

endpackage

[sv/sts_step.sv]
// ============================================================================
// Script token splitter step logic
// Combinational next-state and result logic for one script byte.
// ============================================================================
module sts_step #(
    parameter int LINE_BITS = sts_pkg::LINE_BITS_DEF
) (
    input  logic [7:0]           i_byte,
    input  logic                 i_first,
    input  logic                 i_last,
    input  sts_pkg::t_mode       i_mode,
    input  logic [LINE_BITS-1:0] i_line,
    input  logic                 i_nl_seen,
    output sts_pkg::t_mode       o_mode,
    output logic [LINE_BITS-1:0] o_line,
    output logic                 o_nl_seen,
    output sts_pkg::t_result     o_result
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    sts_pkg::t_mode       mode0;
    sts_pkg::t_mode       mode_n;
    logic [LINE_BITS-1:0] line0;
    logic                 nl0;
    logic                 nl_n;
    logic                 count;
    logic                 is_ws;
    logic                 is_lf;
    logic                 is_semi;
    logic                 is_quote;
    logic                 is_cr;
    logic                 cv;
    logic                 ts;
    logic                 te;
    logic                 qt;
    logic                 in_tok;
    logic [LINE_BITS+sts_pkg::LINE_OUT_W-1:0] line_ext;

    // Byte classes.
    assign is_ws    = (i_byte <= sts_pkg::CH_SPACE);
    assign is_lf    = (i_byte == sts_pkg::CH_LF);
    assign is_semi  = (i_byte == sts_pkg::CH_SEMI);
    assign is_quote = (i_byte == sts_pkg::CH_QUOTE);
    assign is_cr    = (i_byte == sts_pkg::CH_CR);

    // A new script restarts the scanner before the byte is taken.
    assign mode0 = i_first ? sts_pkg::MODE_SKIP : i_mode;
    assign line0 = i_first ? LINE_ONE : i_line;
    assign nl0   = i_first ? 1'b0 : i_nl_seen;

    // Mode transitions and token marks.
    always_comb begin
        mode_n = mode0;
        nl_n   = nl0;
        count  = 1'b0;
        cv     = 1'b0;
        ts     = 1'b0;
        te     = 1'b0;
        qt     = 1'b0;
        in_tok = 1'b0;
        case (mode0)
            sts_pkg::MODE_QUOTED: begin
                in_tok = 1'b1;
                qt     = 1'b1;
                if (is_quote) begin
                    te     = 1'b1;
                    mode_n = sts_pkg::MODE_SKIP;
                    nl_n   = 1'b0;
                end else begin
                    cv    = !is_cr;
                    count = is_lf;
                end
            end
            sts_pkg::MODE_PLAIN: begin
                in_tok = 1'b1;
                if (!is_ws && !is_semi) begin
                    cv = 1'b1;
                end else begin
                    // The terminator is then treated as a skipped byte.
                    te     = 1'b1;
                    mode_n = is_semi ? sts_pkg::MODE_COMMENT : sts_pkg::MODE_SKIP;
                    nl_n   = is_lf;
                    count  = is_lf;
                end
            end
            sts_pkg::MODE_COMMENT: begin
                if (is_lf) begin
                    count  = 1'b1;
                    nl_n   = 1'b1;
                    mode_n = sts_pkg::MODE_SKIP;
                end
            end
            default: begin
                if (is_ws) begin
                    if (is_lf) begin
                        count = 1'b1;
                        nl_n  = 1'b1;
                    end
                end else if (is_semi) begin
                    mode_n = sts_pkg::MODE_COMMENT;
                end else begin
                    ts     = 1'b1;
                    in_tok = 1'b1;
                    if (is_quote) begin
                        mode_n = sts_pkg::MODE_QUOTED;
                        qt     = 1'b1;
                    end else begin
                        mode_n = sts_pkg::MODE_PLAIN;
                        cv     = 1'b1;
                    end
                end
            end
        endcase

        // The final byte of a script closes any open token.
        if (i_last) begin
            if (mode_n == sts_pkg::MODE_QUOTED || mode_n == sts_pkg::MODE_PLAIN) begin
                te   = 1'b1;
                nl_n = 1'b0;
            end
            mode_n = sts_pkg::MODE_SKIP;
        end
    end

    // Saturating line counter.
    assign o_line    = (count && line0 != LINE_MAX) ? line0 + LINE_ONE : line0;
    assign o_mode    = mode_n;
    assign o_nl_seen = nl_n;

    // Result item; the line number is shown in its low bits.
    assign line_ext = {{sts_pkg::LINE_OUT_W{1'b0}}, o_line};

    always_comb begin
        o_result.char_out    = cv ? i_byte : 8'h00;
        o_result.char_valid  = cv;
        o_result.token_start = ts;
        o_result.token_end   = te;
        o_result.is_quoted   = qt;
        o_result.spans_lines = in_tok & nl0;
        o_result.line_now    = line_ext[sts_pkg::LINE_OUT_W-1:0];
    end

endmodule

[sv/script_token_splitter_core.sv]
// ============================================================================
// Script token splitter core
// Splits a script byte stream into tokens, one result item per byte.
// ============================================================================
// Each byte passes through the input register and then the result register
// before its result item is shown on the master side.
// Throughput: one byte per cycle while the master side takes results.
// Reset (synchronous, active low): both stages empty, mode skipping,
// line counter 1, newline flag clear.
module script_token_splitter_core #(
    parameter int LINE_BITS = sts_pkg::LINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tuser,   // [0] first
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] char_out, [23:8] line_now
    output logic [3:0]  m_axis_tuser,   // [0] char_valid, [1] token_start,
                                        // [2] is_quoted, [3] spans_lines
    output logic        m_axis_tlast    // token_end
);

    localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

    // Input stage.
    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_first;
    logic                 r_last;

    // Scanner state.
    sts_pkg::t_mode       r_mode;
    logic [LINE_BITS-1:0] r_line;
    logic                 r_nl_seen;

    // Result stage.
    logic                 r_out_valid;
    sts_pkg::t_result     r_result;

    sts_pkg::t_mode       n_mode;
    logic [LINE_BITS-1:0] n_line;
    logic                 n_nl_seen;
    sts_pkg::t_result     n_result;
    logic                 out_load;

    // The result register takes an item when it is empty or being drained.
    assign out_load      = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || out_load;

    sts_step #(
        .LINE_BITS (LINE_BITS)
    ) u_step (
        .i_byte    (r_byte),
        .i_first   (r_first),
        .i_last    (r_last),
        .i_mode    (r_mode),
        .i_line    (r_line),
        .i_nl_seen (r_nl_seen),
        .o_mode    (n_mode),
        .o_line    (n_line),
        .o_nl_seen (n_nl_seen),
        .o_result  (n_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte  <= s_axis_tdata;
            r_first <= s_axis_tuser;
            r_last  <= s_axis_tlast;
        end
    end

    // Scanner state advances as each item moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= sts_pkg::MODE_SKIP;
            r_line    <= LINE_ONE;
            r_nl_seen <= 1'b0;
        end else if (out_load) begin
            r_mode    <= n_mode;
            r_line    <= n_line;
            r_nl_seen <= n_nl_seen;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_result.line_now, r_result.char_out};
    assign m_axis_tuser  = {r_result.spans_lines, r_result.is_quoted,
                            r_result.token_start, r_result.char_valid};
    assign m_axis_tlast  = r_result.token_end;

    // The line counter never drops below one.
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");

    // A plain token opens on a character; a quoted one opens on its quote.
    a_start_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.token_start) |->
            (r_result.char_valid != r_result.is_quoted))
        else $error("token start with wrong character flag");

    // Bytes outside a token carry no character.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.char_valid) |-> (r_result.char_out == 8'h00))
        else $error("char_out not cleared outside a token");

    // An open token always holds the scanner in a token mode or ends here.
    a_mode_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_result.token_start && !n_result.token_end) |=>
            (r_mode == sts_pkg::MODE_QUOTED || r_mode == sts_pkg::MODE_PLAIN))
        else $error("token opened without entering a token mode");

endmodule
